// File: sv/dual_stack_shared_buffer_unit_defines.svh
// Assertion macros for the dual stack shared buffer unit.
// Taken in by the top level; needs clk and rst_n in scope at the point of use.
`ifndef DUAL_STACK_SHARED_BUFFER_UNIT_DEFINES_SVH
`define DUAL_STACK_SHARED_BUFFER_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define DSSB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DSSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dssb_pkg.sv
// Shared types, codes and constants for the dual stack shared buffer unit.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package dssb_pkg;

  localparam int MemDepthDef  = 64;
  localparam int KeyWidthDef  = 32;
  localparam int CapW         = 6;
  localparam int InitCapW     = 5;
  localparam int MaxGrW       = 2;
  localparam int ValW         = 32;
  localparam int CfgAddrW     = 3;
  localparam int CfgDataW     = 32;

  localparam logic [InitCapW-1:0] InitCapReset    = 5'd10;
  localparam logic [MaxGrW-1:0]   MaxGrowthsReset = 2'd3;

  typedef enum logic [1:0] {
    CmdPushLow  = 2'd0,
    CmdPushHigh = 2'd1,
    CmdPopLow   = 2'd2,
    CmdPopHigh  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StGrown = 2'd1,
    StFull  = 2'd2,
    StEmpty = 2'd3
  } status_t;

  typedef enum logic {
    RegInitCap    = 1'b0,
    RegMaxGrowths = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic signed [ValW-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic signed [ValW-1:0] popped_value;
    logic [CapW-1:0]        capacity_now;
  } out_item_t;

  // Register file view handed to the control path
  typedef struct packed {
    logic                restart;
    logic [InitCapW-1:0] init_cap;
    logic [MaxGrW-1:0]   max_growths;
  } cfg_ctl_t;

  // Memory strobes for one access
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Registered result bookkeeping; the popped key comes from the memory
  typedef struct packed {
    logic            valid;
    status_t         status;
    logic [CapW-1:0] capacity;
    logic            pop_ok;
  } ctrl_res_t;

  // Clip a capacity to the physical limit
  function automatic logic [CapW-1:0] limit_cap(input logic [CapW:0] c,
                                                input logic [CapW-1:0] lim);
    logic [CapW-1:0] r;
    r = (c > {1'b0, lim}) ? lim : c[CapW-1:0];
    return r;
  endfunction

endpackage

// File: sv/dssb_cfg.sv
// APB-style register file: initial capacity and growth budget.
// Depends on dssb_pkg.
`timescale 1ns / 1ps

module dssb_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dssb_pkg::CfgAddrW-1:0]   paddr,
  input  logic [dssb_pkg::CfgDataW-1:0]   pwdata,
  output logic [dssb_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  output dssb_pkg::cfg_ctl_t              cfg_ctl
);
  import dssb_pkg::*;

  logic [InitCapW-1:0] init_cap_r, init_cap_nxt;
  logic [MaxGrW-1:0]   max_growths_r, max_growths_nxt;
  logic                wr_beat;
  reg_idx_t            idx;

  assign pready  = 1'b1;
  assign wr_beat = psel & penable & pwrite;
  assign idx     = reg_idx_t'(paddr[2]);

  // Decode the write beat
  always_comb begin
    init_cap_nxt    = init_cap_r;
    max_growths_nxt = max_growths_r;
    if (wr_beat) begin
      unique case (idx)
        RegInitCap:    init_cap_nxt    = pwdata[InitCapW-1:0];
        RegMaxGrowths: max_growths_nxt = pwdata[MaxGrW-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cap_r    <= InitCapReset;
      max_growths_r <= MaxGrowthsReset;
    end else begin
      init_cap_r    <= init_cap_nxt;
      max_growths_r <= max_growths_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      RegInitCap:    prdata = CfgDataW'(init_cap_r);
      RegMaxGrowths: prdata = CfgDataW'(max_growths_r);
      default:       prdata = '0;
    endcase
  end

  // A write of the initial capacity restarts both stacks with the new value
  assign cfg_ctl.restart     = wr_beat && (idx == RegInitCap);
  assign cfg_ctl.init_cap    = pwdata[InitCapW-1:0];
  assign cfg_ctl.max_growths = max_growths_r;

endmodule

// File: sv/dssb_store.sv
// Key store shared by both stacks: one write or one read per cycle.
// Synchronous memory with registered read data. Depends on dssb_pkg.
`timescale 1ns / 1ps

module dssb_store #(
  parameter int MEM_DEPTH = dssb_pkg::MemDepthDef,
  parameter int KEY_WIDTH = dssb_pkg::KeyWidthDef
) (
  input  logic                          clk,
  input  dssb_pkg::mem_ctl_t            mem_ctl,
  input  logic [$clog2(MEM_DEPTH)-1:0]  addr,
  input  logic [KEY_WIDTH-1:0]          wdata,
  output logic [KEY_WIDTH-1:0]          rdata
);
  import dssb_pkg::*;

  logic [KEY_WIDTH-1:0] mem [MEM_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_r;

  // Write the pushed key
  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  // Read the popped key
  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/dssb_ctrl.sv
// Stack pointers, capacity growth and status decision for each item.
// Drives the key store address and strobes. Depends on dssb_pkg.
`timescale 1ns / 1ps

module dssb_ctrl #(
  parameter int MEM_DEPTH = dssb_pkg::MemDepthDef,
  parameter int KEY_WIDTH = dssb_pkg::KeyWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  dssb_pkg::in_item_t            item,
  input  dssb_pkg::cfg_ctl_t            cfg_ctl,
  output dssb_pkg::mem_ctl_t            mem_ctl,
  output logic [$clog2(MEM_DEPTH)-1:0]  addr,
  output logic [KEY_WIDTH-1:0]          wdata,
  output dssb_pkg::ctrl_res_t           res,
  output logic [dssb_pkg::CapW:0]       fill_sum,
  output logic [dssb_pkg::CapW-1:0]     capacity
);
  import dssb_pkg::*;

  localparam int AW    = $clog2(MEM_DEPTH);
  localparam int CalcW = ((AW > CapW) ? AW : CapW) + 1;
  localparam logic [CapW-1:0]  CapLimit  = CapW'((MEM_DEPTH < 63) ? MEM_DEPTH : 63);
  localparam logic [CalcW-1:0] DepthCalc = CalcW'(MEM_DEPTH);

  logic [CapW-1:0]   fill_low_r, fill_low_nxt;
  logic [CapW-1:0]   fill_high_r, fill_high_nxt;
  logic [CapW-1:0]   cap_r, cap_nxt;
  logic [MaxGrW-1:0] used_r, used_nxt;
  ctrl_res_t         res_r, res_nxt;

  logic [CapW:0]     sum;
  logic [CapW:0]     grown_raw;
  logic [CapW-1:0]   grown;
  logic              full;
  logic              can_grow;
  logic [CalcW-1:0]  addr_calc;

  assign sum       = {1'b0, fill_low_r} + {1'b0, fill_high_r};
  assign full      = sum >= {1'b0, cap_r};
  assign grown_raw = {1'b0, cap_r} + {2'b0, cap_r[CapW-1:1]};
  assign grown     = limit_cap(grown_raw, CapLimit);
  assign can_grow  = (used_r < cfg_ctl.max_growths) && ({1'b0, grown} > sum);

  // Key as stored: low bits of the pushed value, zero filled when wider
  if (KEY_WIDTH >= ValW) begin : g_wide_key
    assign wdata = KEY_WIDTH'(unsigned'(item.push_value));
  end else begin : g_narrow_key
    assign wdata = item.push_value[KEY_WIDTH-1:0];
  end

  // Decide the item: status, pointer moves and memory access
  always_comb begin
    fill_low_nxt  = fill_low_r;
    fill_high_nxt = fill_high_r;
    cap_nxt       = cap_r;
    used_nxt      = used_r;
    mem_ctl       = '{we: 1'b0, re: 1'b0};
    addr_calc     = CalcW'(fill_low_r);
    res_nxt       = '{valid: 1'b0, status: StDone, capacity: cap_r, pop_ok: 1'b0};
    if (cfg_ctl.restart) begin
      fill_low_nxt  = '0;
      fill_high_nxt = '0;
      used_nxt      = '0;
      cap_nxt       = limit_cap({2'b0, cfg_ctl.init_cap}, CapLimit);
    end else if (accept) begin
      res_nxt.valid = 1'b1;
      unique case (item.cmd)
        CmdPushLow, CmdPushHigh: begin
          if (full && !can_grow) begin
            res_nxt.status = StFull;
          end else begin
            if (full) begin
              cap_nxt        = grown;
              used_nxt       = used_r + 1'b1;
              res_nxt.status = StGrown;
            end
            mem_ctl.we = 1'b1;
            if (item.cmd == CmdPushLow) begin
              addr_calc    = CalcW'(fill_low_r);
              fill_low_nxt = fill_low_r + 1'b1;
            end else begin
              addr_calc     = DepthCalc - CalcW'(fill_high_r) - CalcW'(1);
              fill_high_nxt = fill_high_r + 1'b1;
            end
          end
        end
        CmdPopLow: begin
          if (fill_low_r == '0) begin
            res_nxt.status = StEmpty;
          end else begin
            mem_ctl.re     = 1'b1;
            res_nxt.pop_ok = 1'b1;
            addr_calc      = CalcW'(fill_low_r) - CalcW'(1);
            fill_low_nxt   = fill_low_r - 1'b1;
          end
        end
        CmdPopHigh: begin
          if (fill_high_r == '0) begin
            res_nxt.status = StEmpty;
          end else begin
            mem_ctl.re     = 1'b1;
            res_nxt.pop_ok = 1'b1;
            addr_calc      = DepthCalc - CalcW'(fill_high_r);
            fill_high_nxt  = fill_high_r - 1'b1;
          end
        end
        default: ;
      endcase
      res_nxt.capacity = cap_nxt;
    end
  end

  assign addr = addr_calc[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_low_r  <= '0;
      fill_high_r <= '0;
      used_r      <= '0;
      cap_r       <= limit_cap({2'b0, InitCapReset}, CapLimit);
      res_r       <= '{valid: 1'b0, status: StDone, capacity: '0, pop_ok: 1'b0};
    end else begin
      fill_low_r  <= fill_low_nxt;
      fill_high_r <= fill_high_nxt;
      used_r      <= used_nxt;
      cap_r       <= cap_nxt;
      res_r       <= res_nxt;
    end
  end

  assign res      = res_r;
  assign fill_sum = sum;
  assign capacity = cap_r;

endmodule

// File: sv/dual_stack_shared_buffer_unit.sv
// Two stacks in one key store. A result beat leaves in the cycle after its item is accepted.
// Throughput: one item per cycle; busy stays low, since each item makes a single access
// to the one-port key store and a pop reads it later than any earlier push wrote it.
// Reset (rst_n, synchronous): both stacks empty, capacity 10, registers at defaults;
// key store contents are left as they are. The receiver cannot stall.
// Depends on dssb_pkg, dssb_cfg, dssb_ctrl, dssb_store and the defines header.
`timescale 1ns / 1ps
`include "dual_stack_shared_buffer_unit_defines.svh"

module dual_stack_shared_buffer_unit #(
  parameter int MEM_DEPTH = dssb_pkg::MemDepthDef,
  parameter int KEY_WIDTH = dssb_pkg::KeyWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  dssb_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output dssb_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dssb_pkg::CfgAddrW-1:0] paddr,
  input  logic [dssb_pkg::CfgDataW-1:0] pwdata,
  output logic [dssb_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import dssb_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  cfg_ctl_t             cfg_ctl;
  mem_ctl_t             mem_ctl;
  ctrl_res_t            res;
  logic [AW-1:0]        addr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [KEY_WIDTH-1:0] rdata;
  logic [CapW:0]        fill_sum;
  logic [CapW-1:0]      capacity;
  logic [ValW-1:0]      key_wide;
  logic                 accept;
  logic                 fill_ok;
  logic                 push_at_full;
  logic                 refused;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  dssb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_ctl (cfg_ctl)
  );

  dssb_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .cfg_ctl  (cfg_ctl),
    .mem_ctl  (mem_ctl),
    .addr     (addr),
    .wdata    (wdata),
    .res      (res),
    .fill_sum (fill_sum),
    .capacity (capacity)
  );

  dssb_store #(
    .MEM_DEPTH (MEM_DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .addr    (addr),
    .wdata   (wdata),
    .rdata   (rdata)
  );

  // Sign extend a narrow key, drop the zero fill of a wide one
  if (KEY_WIDTH >= ValW) begin : g_wide_pop
    assign key_wide = rdata[ValW-1:0];
  end else begin : g_narrow_pop
    assign key_wide = {{(ValW - KEY_WIDTH){rdata[KEY_WIDTH-1]}}, rdata};
  end

  // Assemble the result beat
  assign out_valid             = res.valid;
  assign out_item.status       = res.status;
  assign out_item.popped_value = res.pop_ok ? signed'(key_wide) : '0;
  assign out_item.capacity_now = res.capacity;

  // Terms watched by the checks below
  assign fill_ok      = (fill_sum <= {1'b0, capacity});
  assign push_at_full = accept && (in_item.cmd == CmdPushLow || in_item.cmd == CmdPushHigh)
                        && (fill_sum >= {1'b0, capacity});
  assign refused      = (out_item.status == StFull);

  `DSSB_ASSERT_NEXT(a_accept_gives_beat, accept, out_valid, "accepted item gave no result beat")
  `DSSB_ASSERT_NEXT(a_no_spurious_beat, !accept, !out_valid, "result beat without an item")
  `DSSB_ASSERT_SAME(a_fill_in_capacity, 1'b1, fill_ok, "stacks overrun capacity")
  `DSSB_ASSERT_NEXT(a_grow_cap, push_at_full, refused || capacity > $past(capacity), "no growth")

endmodule

// File: test/dssb_result_checker.sv
// Result checker for the dual stack shared buffer unit: watches the command, result and
// register ports, predicts each result beat and compares it field by field.
// Depends on dssb_pkg for the item types, codes and register indexes.
`timescale 1ns / 1ps

module dssb_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  dssb_pkg::in_item_t            in_item,
  input  logic                          out_valid,
  input  dssb_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dssb_pkg::CfgAddrW-1:0] paddr,
  input  logic [dssb_pkg::CfgDataW-1:0] pwdata,
  input  logic                          pready,
  output int                            pending,
  output int                            fail_count
);
  import dssb_pkg::*;

  localparam int CapCeil = (MemDepthDef < 63) ? MemDepthDef : 63;

  // Shadow of the block: key store, stack depths, capacity and registers
  logic signed [ValW-1:0] key_mem [MemDepthDef];
  int unsigned            low_depth;
  int unsigned            high_depth;
  int unsigned            cap_now;
  int unsigned            growths_spent;
  logic [InitCapW-1:0]    init_cap_reg;
  logic [MaxGrW-1:0]      max_growths_reg;

  out_item_t              awaited_results [$];

  // Empty both stacks and reload the capacity from the register
  function automatic void empty_stacks();
    low_depth     = 0;
    high_depth    = 0;
    growths_spent = 0;
    cap_now       = (init_cap_reg > CapCeil) ? CapCeil : init_cap_reg;
  endfunction

  // Apply one command to the shadow state and return the result it produces
  function automatic out_item_t apply_stack_cmd(in_item_t it);
    out_item_t   r;
    int unsigned grown;
    r.status       = StDone;
    r.popped_value = '0;
    case (it.cmd)
      CmdPushLow, CmdPushHigh: begin
        // Stacks meet: try to grow, refuse when growth is spent or gains nothing
        if (low_depth + high_depth >= cap_now) begin
          grown = cap_now + (cap_now >> 1);
          if (grown > CapCeil) grown = CapCeil;
          if (growths_spent < max_growths_reg && grown > low_depth + high_depth) begin
            cap_now = grown;
            growths_spent++;
            r.status = StGrown;
          end else begin
            r.status = StFull;
          end
        end
        if (r.status != StFull) begin
          if (it.cmd == CmdPushLow) begin
            key_mem[low_depth] = it.push_value;
            low_depth++;
          end else begin
            high_depth++;
            key_mem[MemDepthDef - high_depth] = it.push_value;
          end
        end
      end
      CmdPopLow: begin
        if (low_depth == 0) begin
          r.status = StEmpty;
        end else begin
          low_depth--;
          r.popped_value = key_mem[low_depth];
        end
      end
      default: begin
        if (high_depth == 0) begin
          r.status = StEmpty;
        end else begin
          r.popped_value = key_mem[MemDepthDef - high_depth];
          high_depth--;
        end
      end
    endcase
    r.capacity_now = CapW'(cap_now);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      init_cap_reg    = InitCapReset;
      max_growths_reg = MaxGrowthsReset;
      empty_stacks();
      awaited_results.delete();
      pending <= 0;
    end else begin
      // Track register writes; a capacity write restarts both stacks
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == RegInitCap) begin
          init_cap_reg = pwdata[InitCapW-1:0];
          empty_stacks();
        end else begin
          max_growths_reg = pwdata[MaxGrW-1:0];
        end
      end
      // Predict each accepted command beat
      if (start && !busy) awaited_results.push_back(apply_stack_cmd(in_item));
      // Compare each result beat with the oldest prediction
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no command awaiting it");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, got %0d", want.popped_value,
                   out_item.popped_value);
            fail_count++;
          end
          if (out_item.capacity_now !== want.capacity_now) begin
            $error("capacity_now: expected %0d, got %0d", want.capacity_now,
                   out_item.capacity_now);
            fail_count++;
          end
        end
      end
      pending <= awaited_results.size();
    end
  end

endmodule

// File: test/dual_stack_shared_buffer_unit_tb.sv
// Testbench top for the dual stack shared buffer unit: clock, reset, register writes and
// command stimulus; the verdict comes from the failure count of dssb_result_checker.
// Depends on dssb_pkg, dssb_result_checker and the block itself.
`timescale 1ns / 1ps

module dual_stack_shared_buffer_unit_tb;
  import dssb_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumSegs    = 6;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  int                  pending;
  int                  fail_count;

  int                  idle_pct;
  int                  beats_sent;
  int                  directed_beats;
  int                  reg_writes;

  // Register settings, length and opening fill burst of each random segment
  int seg_cap   [NumSegs] = '{31, 2, 16, 7, 31, 2};
  int seg_maxg  [NumSegs] = '{3, 0, 3, 1, 2, 3};
  int seg_beats [NumSegs] = '{140, 60, 120, 80, 120, 80};
  int seg_fill  [NumSegs] = '{90, 10, 50, 20, 60, 20};

  dual_stack_shared_buffer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dssb_result_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .pending   (pending),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // Send one command beat, idling first at the current rate, then hold until accepted
  task automatic send_cmd(cmd_t c, logic signed [ValW-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_item.cmd        <= c;
    in_item.push_value <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  // Drain outstanding results, then write one register through setup and access
  task automatic write_reg(reg_idx_t idx, int val);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CfgDataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // Mostly random keys, with the extremes mixed in
  function automatic logic signed [ValW-1:0] pick_key();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Push-heavy bursts fill toward the capacity, pop-heavy bursts drain to empty
  function automatic cmd_t pick_cmd(bit push_heavy);
    bit is_push;
    is_push = push_heavy ? ($urandom_range(99) < 88) : ($urandom_range(99) < 25);
    if (is_push) return $urandom_range(1) ? CmdPushHigh : CmdPushLow;
    return $urandom_range(1) ? CmdPopHigh : CmdPopLow;
  endfunction

  initial begin
    bit push_heavy;
    int burst_end;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idle_pct       = 20;
    beats_sent     = 0;
    reg_writes     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops at reset settings
    send_cmd(CmdPopLow, 32'sd5);
    send_cmd(CmdPopHigh, 32'sd6);
    // Capacity 2 with one growth: grow once, then refuse
    write_reg(RegMaxGrowths, 1);
    write_reg(RegInitCap, 2);
    send_cmd(CmdPushLow, 32'sh7FFF_FFFF);
    send_cmd(CmdPushHigh, 32'sh8000_0000);
    send_cmd(CmdPushLow, -32'sd1);
    send_cmd(CmdPushHigh, '0);
    send_cmd(CmdPopHigh, '0);
    send_cmd(CmdPopHigh, '0);
    send_cmd(CmdPopLow, '0);
    send_cmd(CmdPopLow, '0);
    send_cmd(CmdPopLow, '0);
    // Lower the growth budget below what was spent: fill the grown capacity, then refuse
    write_reg(RegMaxGrowths, 0);
    send_cmd(CmdPushLow, 32'sh1234_5678);
    send_cmd(CmdPushHigh, 32'shFEDC_BA98);
    send_cmd(CmdPushLow, 32'sh0F0F_0F0F);
    send_cmd(CmdPushHigh, 32'shF0F0_F0F0);
    // Tiny capacities: growth gains nothing, so the push is refused
    write_reg(RegMaxGrowths, 3);
    write_reg(RegInitCap, 1);
    send_cmd(CmdPushHigh, 32'sh5555_5555);
    send_cmd(CmdPushLow, 32'shAAAA_AAAA);
    send_cmd(CmdPopHigh, '0);
    write_reg(RegInitCap, 0);
    send_cmd(CmdPushLow, 32'sd1);
    send_cmd(CmdPopHigh, '0);
    directed_beats = beats_sent;

    // Random segments across register settings and sender idle profiles
    for (int s = 0; s < NumSegs; s++) begin
      idle_pct = (s < 2) ? 20 : (s < 4) ? 84 : 0;
      write_reg(RegMaxGrowths, seg_maxg[s]);
      write_reg(RegInitCap, seg_cap[s]);
      push_heavy = 1'b1;
      burst_end  = seg_fill[s];
      for (int i = 0; i < seg_beats[s]; i++) begin
        if (i == burst_end) begin
          push_heavy = !push_heavy;
          burst_end  = i + $urandom_range(10, 40);
        end
        send_cmd(pick_cmd(push_heavy), pick_key());
      end
    end

    // Drain and let the last result settle
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    $display("Covered %0d command beats (%0d directed) over %0d register writes,",
             beats_sent, directed_beats, reg_writes);
    $display("sender idle at 20, 84 and 0 percent, capacities from 0 up to the ceiling.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/dssb_pkg.sv
sv/dssb_cfg.sv
sv/dssb_store.sv
sv/dssb_ctrl.sv
sv/dual_stack_shared_buffer_unit.sv
test/dssb_result_checker.sv
test/dual_stack_shared_buffer_unit_tb.sv
